/* rtl/core/agc_pkg.sv */
// Shared types and constants for the autoranging gain control block.
// Holds the register map, the configuration struct and the fixed-point constants.
// No dependencies.
`default_nettype none

package agc_pkg;

  // Fixed-point format of the smoothed magnitude: unsigned, 16 fraction bits.
  localparam int unsigned FRAC_BITS = 16;

  // Smoothing weight alpha = 0.1 held as 6554 / 65536, and its complement.
  localparam logic [15:0] ALPHA_Q16 = 16'd6554;
  localparam logic [15:0] DECAY_Q16 = 16'd58982;

  // Percent comparisons multiply the level by this instead of dividing.
  localparam logic [6:0] PERCENT_SCALE = 7'd100;

  // Field widths fixed by the register map and the result item.
  localparam int unsigned FS_BITS       = 16;
  localparam int unsigned PCT_BITS      = 7;
  localparam int unsigned COUNT_BITS    = 5;
  localparam int unsigned LEVEL_BITS    = 16;
  localparam int unsigned GAIN_OUT_BITS = 4;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 16;

  // Threshold product of a percent and the full scale.
  localparam int unsigned THR_PROD_BITS = FS_BITS + PCT_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FULL_SCALE   = 3'd0,
    REG_UPPER_PCT    = 3'd1,
    REG_LOWER_PCT    = 3'd2,
    REG_HYST_PCT     = 3'd3,
    REG_GAIN_COUNT   = 3'd4
  } agc_reg_e;

  typedef struct packed {
    logic [FS_BITS-1:0]    fs_level;
    logic [PCT_BITS-1:0]   upper_percent;
    logic [PCT_BITS-1:0]   lower_percent;
    logic [PCT_BITS-1:0]   hyst_percent;
    logic [COUNT_BITS-1:0] gain_count;
  } agc_cfg_t;

  localparam logic [FS_BITS-1:0]    RST_FULL_SCALE = 16'd32768;
  localparam logic [PCT_BITS-1:0]   RST_UPPER_PCT  = 7'd90;
  localparam logic [PCT_BITS-1:0]   RST_LOWER_PCT  = 7'd10;
  localparam logic [PCT_BITS-1:0]   RST_HYST_PCT   = 7'd5;
  localparam logic [COUNT_BITS-1:0] RST_GAIN_COUNT = 5'd16;

endpackage

`default_nettype wire

/* rtl/core/agc_level_filter.sv */
// Smoothed magnitude stage of the autoranging gain control.
// Holds the level estimate and applies one exponential smoothing step per transaction unless held.
// Depends on agc_pkg.
`default_nettype none

module agc_level_filter #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         rst_ni,
  input  wire logic                                         en_i,
  input  wire logic                                         hold_i,
  input  wire logic signed [SAMPLE_BITS-1:0]                sample_i,
  output logic [SAMPLE_BITS+agc_pkg::FRAC_BITS-1:0]         est_o
);
  import agc_pkg::*;

  localparam int unsigned EstBits  = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned ProdBits = EstBits + 16;

  logic [SAMPLE_BITS-1:0] mag;
  logic [EstBits-1:0]     attack;
  logic [ProdBits-1:0]    decay_prod;
  logic [EstBits-1:0]     sum;
  logic [EstBits-1:0]     est_d, est_q;

  // The most negative sample gives 2^(SAMPLE_BITS-1), which still fits unsigned.
  assign mag = sample_i[SAMPLE_BITS-1] ? (~sample_i + SAMPLE_BITS'(1)) : sample_i;

  // alpha*|x| lands on whole units, so only the decay term needs flooring.
  // The estimate is a weighted mean of magnitudes, so the sum never overflows.
  assign attack     = EstBits'(mag) * EstBits'(ALPHA_Q16);
  assign decay_prod = ProdBits'(est_q) * ProdBits'(DECAY_Q16);
  assign sum        = attack + decay_prod[ProdBits-1:FRAC_BITS];

  always_comb begin
    est_d = est_q;
    if (en_i && !hold_i) begin
      est_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q <= '0;
    end else begin
      est_q <= est_d;
    end
  end

  assign est_o = est_q;

endmodule

`default_nettype wire

/* rtl/core/agc_gain_step.sv */
// Gain index stage of the autoranging gain control.
// Compares the level with percent thresholds, steps the gain index and registers the result.
// Depends on agc_pkg.
`default_nettype none

module agc_gain_step #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_GAINS   = 16
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          en_i,
  input  wire agc_pkg::agc_cfg_t                             cfg_i,
  input  wire logic [SAMPLE_BITS+agc_pkg::FRAC_BITS-1:0]     est_i,
  output logic [agc_pkg::GAIN_OUT_BITS-1:0]                  gain_index_o,
  output logic [agc_pkg::LEVEL_BITS-1:0]                     level_o,
  output logic                                               gain_changed_o
);
  import agc_pkg::*;

  localparam int unsigned EstBits  = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned GainBits = (MAX_GAINS > 1) ? $clog2(MAX_GAINS) : 1;
  localparam int unsigned CntBits  = (GainBits + 1 > COUNT_BITS) ? GainBits + 1 : COUNT_BITS;
  localparam int unsigned ThrBits  = THR_PROD_BITS + FRAC_BITS;
  localparam int unsigned CmpBits  = (EstBits + PCT_BITS > ThrBits) ?
                                     EstBits + PCT_BITS : ThrBits;

  logic [GainBits-1:0]      gain_d, gain_q;
  logic [CntBits-1:0]       count_eff;
  logic [CntBits-1:0]       gain_plus;
  logic [PCT_BITS-1:0]      hyst_diff;
  logic [THR_PROD_BITS-1:0] up_prod, low_prod, hyst_prod;
  logic [CmpBits-1:0]       scaled, thr_up, thr_low, thr_hyst;
  logic                     step_down, step_up;
  logic [GainBits+GAIN_OUT_BITS-1:0] gain_wide;
  logic [EstBits+LEVEL_BITS-1:0]     est_wide;

  assign count_eff = (CntBits'(cfg_i.gain_count) > CntBits'(MAX_GAINS)) ?
                     CntBits'(MAX_GAINS) : CntBits'(cfg_i.gain_count);
  assign gain_plus = CntBits'(gain_q) + CntBits'(1);
  assign hyst_diff = cfg_i.lower_percent - cfg_i.hyst_percent;

  assign up_prod   = THR_PROD_BITS'(cfg_i.upper_percent) * THR_PROD_BITS'(cfg_i.fs_level);
  assign low_prod  = THR_PROD_BITS'(cfg_i.lower_percent) * THR_PROD_BITS'(cfg_i.fs_level);
  assign hyst_prod = THR_PROD_BITS'(hyst_diff) * THR_PROD_BITS'(cfg_i.fs_level);

  assign scaled   = CmpBits'(est_i) * CmpBits'(PERCENT_SCALE);
  assign thr_up   = CmpBits'({up_prod, {FRAC_BITS{1'b0}}});
  assign thr_low  = CmpBits'({low_prod, {FRAC_BITS{1'b0}}});
  assign thr_hyst = CmpBits'({hyst_prod, {FRAC_BITS{1'b0}}});

  assign step_down = (scaled > thr_up) && (gain_q != '0);
  // A negative step-up threshold (hysteresis above lower percent) never fires.
  assign step_up   = (scaled < thr_low) && (gain_plus < count_eff) &&
                     (cfg_i.lower_percent >= cfg_i.hyst_percent) &&
                     (scaled < thr_hyst);

  always_comb begin
    gain_d = gain_q;
    if (cfg_i.gain_count != '0) begin
      priority if (step_up) begin
        gain_d = gain_plus[GainBits-1:0];
      end else if (step_down) begin
        gain_d = gain_q - GainBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= '0;
    end else if (en_i) begin
      gain_q <= gain_d;
    end
  end

  assign gain_wide = (GainBits+GAIN_OUT_BITS)'(gain_d);
  assign est_wide  = (EstBits+LEVEL_BITS)'(est_i);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gain_index_o   <= gain_wide[GAIN_OUT_BITS-1:0];
      level_o        <= est_wide[FRAC_BITS +: LEVEL_BITS];
      gain_changed_o <= (gain_d != gain_q);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/autorange_gain_control.sv */
// Autoranging gain control: an accepted sample reaches the output through the input
// register, the level stage and the result register, in that order.
// Throughput is one sample per cycle; a stalled output backs up the three stages in turn.
// Reset is asynchronous and active low: the level estimate and gain index clear to zero,
// the configuration registers return to their defaults and the pipeline empties.
`default_nettype none

module autorange_gain_control #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned MAX_GAINS   = 16
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  // Sample channel.
  input  wire logic                                    in_valid_i,
  output logic                                         in_stall_o,
  input  wire logic signed [SAMPLE_BITS-1:0]           sample_i,
  // Result channel.
  output logic                                         out_valid_o,
  input  wire logic                                    out_stall_i,
  output logic [agc_pkg::GAIN_OUT_BITS-1:0]            gain_index_o,
  output logic [agc_pkg::LEVEL_BITS-1:0]               level_o,
  output logic                                         gain_changed_o,
  // Configuration write channel.
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [agc_pkg::CFG_IDX_BITS-1:0]        cfg_index_i,
  input  wire logic [agc_pkg::CFG_DATA_BITS-1:0]       cfg_data_i
);
  import agc_pkg::*;

  localparam int unsigned EstBits = SAMPLE_BITS + FRAC_BITS;

  // The pipeline has three stages: the input register, the level stage (which
  // commits the new estimate as the sample enters it) and the result register
  // (which commits the new gain index as the item enters it). Each stage moves
  // forward when the stage after it is empty or is being emptied this cycle.

  agc_cfg_t cfg_d, cfg_q;

  logic                          s1_valid_d, s1_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          s2_valid_d, s2_valid_q;
  logic                          out_valid_d, out_valid_q;
  logic                          s3_free, s2_free, s1_free;
  logic                          s1_adv, s2_adv, in_accept;
  logic [EstBits-1:0]            est;

  assign s3_free   = !out_valid_q || !out_stall_i;
  assign s2_free   = !s2_valid_q || s3_free;
  assign s1_free   = !s1_valid_q || s2_free;
  assign s2_adv    = s2_valid_q && s3_free;
  assign s1_adv    = s1_valid_q && s2_free;
  assign in_accept = in_valid_i && s1_free;

  assign in_stall_o  = !s1_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    s1_valid_d  = s1_free ? in_valid_i : s1_valid_q;
    s2_valid_d  = s2_free ? s1_valid_q : s2_valid_q;
    out_valid_d = s3_free ? s2_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      s2_valid_q  <= s2_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // The sample register carries payload only and needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q <= sample_i;
    end
  end

  // Configuration writes are always taken. Writes to an index past the
  // register map are dropped; wider data is cut to each register's width.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (agc_reg_e'(cfg_index_i))
        REG_FULL_SCALE: cfg_d.fs_level      = cfg_data_i[FS_BITS-1:0];
        REG_UPPER_PCT:  cfg_d.upper_percent = cfg_data_i[PCT_BITS-1:0];
        REG_LOWER_PCT:  cfg_d.lower_percent = cfg_data_i[PCT_BITS-1:0];
        REG_HYST_PCT:   cfg_d.hyst_percent  = cfg_data_i[PCT_BITS-1:0];
        REG_GAIN_COUNT: cfg_d.gain_count    = cfg_data_i[COUNT_BITS-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fs_level      <= RST_FULL_SCALE;
      cfg_q.upper_percent <= RST_UPPER_PCT;
      cfg_q.lower_percent <= RST_LOWER_PCT;
      cfg_q.hyst_percent  <= RST_HYST_PCT;
      cfg_q.gain_count    <= RST_GAIN_COUNT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Level stage. With a gain count of zero the sample leaves the estimate alone.
  agc_level_filter #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_level (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (s1_adv),
    .hold_i  (cfg_q.gain_count == '0),
    .sample_i(sample_q),
    .est_o   (est)
  );

  // Gain stage and result register. It reads the estimate committed for the
  // item now leaving the level stage, so the two recurrences stay in order.
  agc_gain_step #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .MAX_GAINS  (MAX_GAINS)
  ) u_gain (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (s2_adv),
    .cfg_i         (cfg_q),
    .est_i         (est),
    .gain_index_o  (gain_index_o),
    .level_o       (level_o),
    .gain_changed_o(gain_changed_o)
  );

endmodule

`default_nettype wire

/* rtl/core/agc_checker.sv */
// Port-level checks for the autoranging gain control and the bind that attaches them.
// Depends on agc_pkg and on the top level autorange_gain_control.
`default_nettype none

module agc_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 in_valid_i,
  input wire logic                                 in_stall_o,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic [agc_pkg::GAIN_OUT_BITS-1:0]    gain_index_o,
  input wire logic [agc_pkg::LEVEL_BITS-1:0]       level_o,
  input wire logic                                 gain_changed_o,
  input wire logic                                 cfg_valid_i,
  input wire logic                                 cfg_ready_o
);

  // A stalled result stays valid and keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gain_index_o) &&
                                   $stable(level_o) && $stable(gain_changed_o))
    else $error("stalled result changed");

  // The input only stalls when the whole pipeline is backed up behind a stalled result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled with room in the pipeline");

  // With the output free, an accepted sample comes out as a valid result.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i |=> out_valid_o)
    else $error("result missing after pipeline latency");

  // The configuration port never pushes back.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind autorange_gain_control agc_checker u_agc_checker (.*);

`default_nettype wire

/* tb/autorange_gain_control_tb.sv */
// Self-checking testbench for autorange_gain_control: it streams signed ADC samples,
// predicts the smoothed level and the gain index, and checks every result transaction.
// Depends on agc_pkg and the autorange_gain_control RTL only.

module autorange_gain_control_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import agc_pkg::*;

  // Smoothing weights of the level tracker in Q0.16, and the percent scale.
  localparam logic [63:0] SMOOTH_WEIGHT = 64'd6554;
  localparam logic [63:0] HOLD_WEIGHT   = 64'd58982;
  localparam logic [63:0] PERCENT_FULL  = 64'd100;
  // Gain slots of the instance; larger gain counts are clipped to this.
  localparam int unsigned GAIN_SLOTS    = 16;
  // Cycles to let pass after the last result before touching the registers.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PLAN_STEPS    = 15;
  localparam int unsigned BURST_ITEMS   = 94;

  typedef struct packed {
    logic [GAIN_OUT_BITS-1:0] gain_index;
    logic [LEVEL_BITS-1:0]    level;
    logic                     gain_changed;
  } gain_result_t;

  // One register setting of the random part, with an optional run of silence at the
  // end that walks the gain index up before the next setting is applied.
  typedef struct {
    logic [FS_BITS-1:0]    fs_level;
    logic [PCT_BITS-1:0]   upper_pct;
    logic [PCT_BITS-1:0]   lower_pct;
    logic [PCT_BITS-1:0]   hyst_pct;
    logic [COUNT_BITS-1:0] gain_count;
    bit                    quiet_tail;
  } range_setting_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [15:0]             adc_sample = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [GAIN_OUT_BITS-1:0] gain_index;
  logic [LEVEL_BITS-1:0]   level;
  logic                    gain_changed;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  agc_reg_e                cfg_index = REG_FULL_SCALE;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  // Predictor state: its own copy of the registers, the Q16.16 level and the gain index.
  agc_cfg_t    range_cfg = '{RST_FULL_SCALE, RST_UPPER_PCT, RST_LOWER_PCT, RST_HYST_PCT,
                             RST_GAIN_COUNT};
  logic [63:0] level_q16 = '0;
  logic [3:0]  gain_now = '0;

  logic [15:0]  pending_adc_samples[$];
  gain_result_t predicted_gain_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  sender_idle_pct = 0;
  int unsigned  stall_pct = 0;

  // Corner samples: both rails, the most negative code, unit steps and alternating bits.
  logic [15:0] corner_values [12] = '{16'h7fff, 16'h8000, 16'h8000, 16'hffff, 16'h0001,
                                      16'h5555, 16'haaaa, 16'h8001, 16'h7ffe, 16'h8000,
                                      16'h8000, 16'h0000};
  range_setting_t range_plan [PLAN_STEPS];

  autorange_gain_control dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .sample_i       (adc_sample),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .gain_index_o   (gain_index),
    .level_o        (level),
    .gain_changed_o (gain_changed),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Advances the level tracker and the gain decision by one sample and returns the
  // result transaction the block must produce for it.
  function automatic gain_result_t track_level_and_gain(logic [15:0] raw);
    logic [15:0]           magnitude;
    logic [63:0]           scaled;
    logic [63:0]           scale_q16;
    logic [COUNT_BITS-1:0] usable;
    logic [3:0]            prior_gain;
    logic [3:0]            next_gain;
    gain_result_t          outcome;
    prior_gain = gain_now;
    next_gain = gain_now;
    usable = (range_cfg.gain_count > GAIN_SLOTS) ? COUNT_BITS'(GAIN_SLOTS)
                                                 : range_cfg.gain_count;
    // With no usable gain the sample is dropped and the held state is reported.
    if (usable != '0) begin
      // The most negative code maps to a magnitude of 32768, which fits in 16 bits.
      magnitude = raw[15] ? (~raw + 16'd1) : raw;
      level_q16 = (SMOOTH_WEIGHT * ({48'd0, magnitude} << 16) + HOLD_WEIGHT * level_q16)
                  >> 16;
      scaled = level_q16 * PERCENT_FULL;
      scale_q16 = {48'd0, range_cfg.fs_level} << 16;
      if (scaled > 64'(range_cfg.upper_percent) * scale_q16 && prior_gain != 4'd0) begin
        next_gain = prior_gain - 4'd1;
      end
      // A step up overrides a step down. A negative step-up threshold blocks it.
      if (scaled < 64'(range_cfg.lower_percent) * scale_q16 &&
          {1'b0, prior_gain} + 5'd1 < usable &&
          range_cfg.lower_percent >= range_cfg.hyst_percent &&
          scaled < 64'(range_cfg.lower_percent - range_cfg.hyst_percent) * scale_q16)
      begin
        next_gain = prior_gain + 4'd1;
      end
      gain_now = next_gain;
    end
    outcome.gain_index = gain_now;
    outcome.level = level_q16[31:16];
    outcome.gain_changed = (gain_now != prior_gain);
    return outcome;
  endfunction

  task automatic record_failure(string what);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s", $time, what);
    end
  endtask

  // Sample driver. A transaction completes on an edge with valid high and stall low;
  // the prediction is made right there, so the expectation order follows acceptance.
  // A stalled sample is held; otherwise the next one is offered unless the sender idles.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted_gain_results.push_back(track_level_and_gain(adc_sample));
      end
      if (!in_valid || !in_stall) begin
        if (pending_adc_samples.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          adc_sample <= pending_adc_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each completed result transaction is checked against the oldest
  // expectation, field by field. The receiver stalls at random at the current rate.
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    gain_result_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_gain_results.size() == 0) begin
          record_failure($sformatf("result with nothing expected: gain %0d level %0d",
                                   gain_index, level));
        end else begin
          want = predicted_gain_results.pop_front();
          if (gain_index !== want.gain_index) begin
            record_failure($sformatf("gain_index expected %0d, got %0d",
                                     want.gain_index, gain_index));
          end
          if (level !== want.level) begin
            record_failure($sformatf("level expected %0d, got %0d", want.level, level));
          end
          if (gain_changed !== want.gain_changed) begin
            record_failure($sformatf("gain_changed expected %0d, got %0d",
                                     want.gain_changed, gain_changed));
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // One register write transaction; the predictor takes the new value once it lands.
  task automatic write_register(agc_reg_e idx, logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FULL_SCALE: range_cfg.fs_level = value[FS_BITS-1:0];
      REG_UPPER_PCT:  range_cfg.upper_percent = value[PCT_BITS-1:0];
      REG_LOWER_PCT:  range_cfg.lower_percent = value[PCT_BITS-1:0];
      REG_HYST_PCT:   range_cfg.hyst_percent = value[PCT_BITS-1:0];
      REG_GAIN_COUNT: range_cfg.gain_count = value[COUNT_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_range_setting(range_setting_t setting);
    write_register(REG_FULL_SCALE, CFG_DATA_BITS'(setting.fs_level));
    write_register(REG_UPPER_PCT, CFG_DATA_BITS'(setting.upper_pct));
    write_register(REG_LOWER_PCT, CFG_DATA_BITS'(setting.lower_pct));
    write_register(REG_HYST_PCT, CFG_DATA_BITS'(setting.hyst_pct));
    write_register(REG_GAIN_COUNT, CFG_DATA_BITS'(setting.gain_count));
  endtask

  // Waits until every queued sample went in and every result came out,
  // then lets the pipeline settle so the registers can be written safely.
  task automatic wait_until_drained();
    do @(posedge clk_i);
    while (pending_adc_samples.size() != 0 || in_valid || predicted_gain_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Random traffic. Most of it is bursts of steady amplitude with random sign, which
  // drive the smoothed level across the thresholds and make the gain index travel;
  // the rest is short runs of unrestricted codes.
  task automatic queue_level_bursts(int unsigned count);
    int unsigned queued;
    int unsigned run;
    int unsigned center;
    int unsigned mag;
    queued = 0;
    while (queued < count) begin
      run = $urandom_range(40, 10);
      if ($urandom_range(9) < 8) begin
        case ($urandom_range(3))
          0:       center = $urandom_range(400, 0);
          1:       center = $urandom_range(6000, 400);
          2:       center = $urandom_range(29000, 6000);
          default: center = $urandom_range(32768, 29000);
        endcase
        repeat (run) begin
          mag = $urandom_range(center, center - center / 16);
          if (mag >= 32768) begin
            pending_adc_samples.push_back($urandom_range(1) ? 16'h8000 : 16'h7fff);
          end else if ($urandom_range(1)) begin
            pending_adc_samples.push_back(16'(-int'(mag)));
          end else begin
            pending_adc_samples.push_back(16'(mag));
          end
        end
      end else begin
        run = $urandom_range(10, 1);
        repeat (run) pending_adc_samples.push_back(16'($urandom));
      end
      queued += run;
    end
  endtask

  initial begin : stimulus
    int unsigned step;
    // Settings cover every register, the extremes of each field, zero and oversize gain
    // counts, a zero full scale, hysteresis past the lower threshold and percents past 100.
    range_plan = '{
      '{16'd32768, 7'd90,  7'd10,  7'd5,   5'd16, 1'b1},
      '{16'd32768, 7'd80,  7'd40,  7'd10,  5'd4,  1'b0},  // index sits above the count
      '{16'd0,     7'd90,  7'd10,  7'd5,   5'd16, 1'b0},
      '{16'd16384, 7'd127, 7'd127, 7'd0,   5'd31, 1'b0},
      '{16'd32768, 7'd90,  7'd10,  7'd20,  5'd16, 1'b0},
      '{16'd32768, 7'd90,  7'd10,  7'd5,   5'd0,  1'b0},
      '{16'd65535, 7'd0,   7'd0,   7'd0,   5'd2,  1'b0},
      '{16'd1,     7'd100, 7'd100, 7'd100, 5'd16, 1'b0},
      '{16'd100,   7'd10,  7'd90,  7'd30,  5'd1,  1'b0},
      '{16'd32768, 7'd50,  7'd30,  7'd0,   5'd8,  1'b0},
      '{16'd32768, 7'd127, 7'd0,   7'd127, 5'd17, 1'b0},
      '{16'd20000, 7'd60,  7'd50,  7'd45,  5'd16, 1'b0},
      '{16'd8000,  7'd95,  7'd60,  7'd10,  5'd12, 1'b0},
      '{16'd32768, 7'd100, 7'd100, 7'd0,   5'd16, 1'b0},
      '{16'd32768, 7'd90,  7'd10,  7'd5,   5'd16, 1'b0}
    };
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // First third: a lazy sender against a receiver that stalls most of the time.
    sender_idle_pct = 25;
    stall_pct = 74;

    // Directed part under the reset settings: silence walks the gain up, then the
    // corner codes, then a run at the negative rail lifts the level.
    repeat (6) pending_adc_samples.push_back(16'h0000);
    foreach (corner_values[i]) pending_adc_samples.push_back(corner_values[i]);
    repeat (6) pending_adc_samples.push_back(16'h8000);
    wait_until_drained();

    for (step = 0; step < PLAN_STEPS; step++) begin
      if (step == 5) begin
        sender_idle_pct = 74;
        stall_pct = 25;
      end else if (step == 10) begin
        sender_idle_pct = 0;
        stall_pct = 0;
      end
      apply_range_setting(range_plan[step]);
      queue_level_bursts(BURST_ITEMS);
      if (range_plan[step].quiet_tail) begin
        repeat (45) pending_adc_samples.push_back(16'h0000);
      end
      wait_until_drained();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run at the heaviest idling and stalling.
  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/agc_pkg.sv
rtl/core/agc_level_filter.sv
rtl/core/agc_gain_step.sv
rtl/core/autorange_gain_control.sv
rtl/core/agc_checker.sv
tb/autorange_gain_control_tb.sv
